/* hw/rtl/tss_pkg.sv */
// Shared types and constants for the thread scheduler with semaphores.
package tss_pkg;

	localparam int unsigned MaxThreads = 16;
	localparam int unsigned MaxSems = 8;

	typedef enum logic [2:0] {
		MODE_CREATE  = 3'd0,
		MODE_TICK    = 3'd1,
		MODE_EXIT    = 3'd2,
		MODE_JOIN    = 3'd3,
		MODE_SINIT   = 3'd4,
		MODE_WAIT    = 3'd5,
		MODE_POST    = 3'd6,
		MODE_DESTROY = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_NOSLOT  = 3'd1,
		STS_BADSEM  = 3'd2,
		STS_BUSY    = 3'd3,
		STS_NONE    = 3'd4,
		STS_UNKNOWN = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		TH_FREE  = 3'd0,
		TH_READY = 3'd1,
		TH_RUN   = 3'd2,
		TH_BLOCK = 3'd3,
		TH_TERM  = 3'd4
	} th_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture transaction, decode
		logic exec;     // perform command body
		logic sched_st; // start schedule (running -> ready)
		logic sched_sl; // examine one slot
	} tss_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_sched; // command ends in a schedule
		logic found;      // examined slot is ready
		logic last;       // examined slot was the final one
	} tss_sts_t;

endpackage

/* hw/rtl/tss_datapath.sv */
// Datapath: thread tables, semaphore tables, command execution and slot scan.
module tss_datapath #(
	parameter int unsigned MAX_THREADS = tss_pkg::MaxThreads,
	parameter int unsigned MAX_SEMS = tss_pkg::MaxSems
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tss_pkg::tss_cmd_t cmd,
	output tss_pkg::tss_sts_t sts,
	input  logic [2:0]       mode,
	input  logic [3:0]       target_thread,
	input  logic [2:0]       sem_index,
	input  logic [15:0]      sem_start_value,
	input  logic [31:0]      exit_word,
	output logic [2:0]       res_status,
	output logic [3:0]       res_created,
	output logic [3:0]       res_running,
	output logic [31:0]      res_jw,
	output logic             res_xr
);
	import tss_pkg::*;

	localparam int unsigned TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int unsigned SW = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
	localparam int unsigned NW = TW + 1;

	th_state_t       th_q [MAX_THREADS];
	logic            jv_q [MAX_THREADS]; // joiner present
	logic [TW-1:0]   jn_q [MAX_THREADS];
	logic [31:0]     ex_q [MAX_THREADS];
	logic            lv_q [MAX_THREADS]; // wait link present
	logic [TW-1:0]   ln_q [MAX_THREADS];
	logic [TW-1:0]   cur_q;
	logic [NW-1:0]   nid_q;
	logic [15:0]     cnt_q [MAX_SEMS];
	logic            live_q [MAX_SEMS];
	logic            hv_q [MAX_SEMS];
	logic [TW-1:0]   hd_q [MAX_SEMS];
	logic [TW-1:0]   tl_q [MAX_SEMS];

	logic [2:0]      mode_q;
	logic [3:0]      tgt_q;
	logic [2:0]      si_q;
	logic [15:0]     start_q;
	logic [31:0]     ew_q;
	logic [TW-1:0]   scan_q;
	logic [NW-1:0]   left_q;
	logic            nsched_q;

	logic [TW-1:0]   tg;
	logic [SW-1:0]   sj;
	logic            tgt_ok, si_ok, sem_ok;
	logic [2:0]      emode;
	logic [TW-1:0]   hd;

	assign tg = TW'(tgt_q);
	assign sj = SW'(si_q);
	assign tgt_ok = ({{(32-4){1'b0}}, tgt_q} < MAX_THREADS);
	assign si_ok = ({{(32-3){1'b0}}, si_q} < MAX_SEMS);
	assign sem_ok = si_ok && live_q[sj];
	assign hd = hd_q[sj];

	always_comb begin
		emode = mode_q;
		if ((mode_q == MODE_EXIT || mode_q == MODE_JOIN || mode_q == MODE_WAIT)
				&& th_q[cur_q] != TH_RUN)
			emode = MODE_TICK;
	end

	assign sts.need_sched = nsched_q;
	assign sts.found = (th_q[scan_q] == TH_READY);
	assign sts.last = (left_q == NW'(1));
	assign res_running = 4'(cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				th_q[i] <= (i == 0) ? TH_RUN : TH_FREE;
				jv_q[i] <= 1'b0;
				lv_q[i] <= 1'b0;
				ex_q[i] <= '0;
			end
			for (int s = 0; s < MAX_SEMS; s++) begin
				cnt_q[s] <= '0;
				live_q[s] <= 1'b0;
				hv_q[s] <= 1'b0;
			end
			cur_q <= '0;
			nid_q <= NW'(1);
			nsched_q <= 1'b0;
			res_status <= STS_OK;
			res_created <= '0;
			res_jw <= '0;
			res_xr <= 1'b0;
		end else begin
			if (cmd.load) begin
				mode_q <= mode;
				tgt_q <= target_thread;
				si_q <= sem_index;
				start_q <= sem_start_value;
				ew_q <= exit_word;
			end
			if (cmd.exec) begin
				res_status <= STS_OK;
				res_created <= '0;
				res_jw <= '0;
				res_xr <= 1'b0;
				nsched_q <= 1'b0;
				case (emode)
					MODE_CREATE: begin
						if ({{(32-NW){1'b0}}, nid_q} >= MAX_THREADS) begin
							res_status <= STS_NOSLOT;
						end else begin
							res_created <= 4'(nid_q);
							th_q[nid_q[TW-1:0]] <= TH_READY;
							jv_q[nid_q[TW-1:0]] <= 1'b0;
							lv_q[nid_q[TW-1:0]] <= 1'b0;
							nid_q <= nid_q + NW'(1);
						end
					end
					MODE_TICK: nsched_q <= 1'b1;
					MODE_EXIT: begin
						th_q[cur_q] <= TH_TERM;
						ex_q[cur_q] <= ew_q;
						if (jv_q[cur_q] && th_q[jn_q[cur_q]] == TH_BLOCK)
							th_q[jn_q[cur_q]] <= TH_READY;
						nsched_q <= 1'b1;
					end
					MODE_JOIN: begin
						if (!tgt_ok || th_q[tg] == TH_FREE) begin
							res_status <= STS_UNKNOWN;
						end else begin
							if (th_q[tg] == TH_TERM) begin
								res_jw <= ex_q[tg];
								res_xr <= 1'b1;
							end else if (!jv_q[tg]) begin
								th_q[cur_q] <= TH_BLOCK;
								jv_q[tg] <= 1'b1;
								jn_q[tg] <= cur_q;
							end
							nsched_q <= 1'b1;
						end
					end
					MODE_SINIT: begin
						if (!si_ok) begin
							res_status <= STS_BADSEM;
						end else if (live_q[sj] && hv_q[sj]) begin
							res_status <= STS_BUSY;
						end else begin
							cnt_q[sj] <= start_q;
							live_q[sj] <= 1'b1;
							hv_q[sj] <= 1'b0;
						end
					end
					MODE_WAIT: begin
						if (!sem_ok) begin
							res_status <= STS_BADSEM;
						end else if (cnt_q[sj] != '0) begin
							cnt_q[sj] <= cnt_q[sj] - 16'd1;
						end else begin
							th_q[cur_q] <= TH_BLOCK;
							lv_q[cur_q] <= 1'b0;
							if (hv_q[sj]) begin
								lv_q[tl_q[sj]] <= 1'b1;
								ln_q[tl_q[sj]] <= cur_q;
							end else begin
								hv_q[sj] <= 1'b1;
								hd_q[sj] <= cur_q;
							end
							tl_q[sj] <= cur_q;
							nsched_q <= 1'b1;
						end
					end
					MODE_POST: begin
						if (!sem_ok) begin
							res_status <= STS_BADSEM;
						end else if (hv_q[sj]) begin
							if (th_q[hd] == TH_BLOCK)
								th_q[hd] <= TH_READY;
							hv_q[sj] <= lv_q[hd];
							hd_q[sj] <= ln_q[hd];
							lv_q[hd] <= 1'b0;
						end else if (cnt_q[sj] != 16'hFFFF) begin
							cnt_q[sj] <= cnt_q[sj] + 16'd1;
						end
					end
					default: begin
						if (!sem_ok) begin
							res_status <= STS_BADSEM;
						end else if (hv_q[sj]) begin
							res_status <= STS_BUSY;
						end else begin
							live_q[sj] <= 1'b0;
							cnt_q[sj] <= '0;
						end
					end
				endcase
			end
			if (cmd.sched_st) begin
				if (th_q[cur_q] == TH_RUN)
					th_q[cur_q] <= TH_READY;
				scan_q <= (cur_q == TW'(MAX_THREADS - 1)) ? '0 : cur_q + TW'(1);
				left_q <= NW'(MAX_THREADS);
			end
			if (cmd.sched_sl) begin
				if (sts.found) begin
					th_q[scan_q] <= TH_RUN;
					cur_q <= scan_q;
				end else if (sts.last) begin
					res_status <= STS_NONE;
				end
				scan_q <= (scan_q == TW'(MAX_THREADS - 1)) ? '0 : scan_q + TW'(1);
				left_q <= left_q - NW'(1);
			end
		end
	end

endmodule

/* hw/rtl/tss_ctrl.sv */
// Controller: sequences load, execute, slot scan and result delivery.
module tss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output tss_pkg::tss_cmd_t cmd,
	input  tss_pkg::tss_sts_t sts
);
	import tss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SST, S_SCAN, S_OUT
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.exec = (state_q == S_EXEC);
		cmd.sched_st = (state_q == S_SST) && sts.need_sched;
		cmd.sched_sl = (state_q == S_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= S_SST;
				S_SST: state_q <= sts.need_sched ? S_SCAN : S_OUT;
				S_SCAN: if (sts.found || sts.last) state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.sched_st, cmd.sched_sl}))
		else $error("multiple commands");
	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("no exec after load");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule

/* hw/rtl/thread_scheduler_with_semaphores.sv */
// Top level of the thread scheduler with semaphores.
// Usage:
//   One command transaction enters on the input channel (valid/stall);
//   each produces exactly one result transaction on the output channel.
//   The block handles one command at a time: in_stall stays high from
//   acceptance until the result has been taken.
// Sequence:
//   Each command passes S_EXEC and S_SST before its result shows in S_OUT.
//   Commands without a schedule (create, semaphore init/post/destroy,
//   a wait that takes a unit, a join of an unknown thread) go straight
//   to S_OUT. Tick, exit, join and a blocking wait add a round-robin
//   scan (S_SCAN) that examines one thread slot per cycle, at most
//   MAX_THREADS slots. The slot scan sets the rate.
// Reset:
//   arst_n resets asynchronously: slot 0 running, other slots free,
//   no joiners, exit values zero, all semaphores dead and empty.
// Stall:
//   While out_stall is high the result is held stable and no new
//   command is taken.
module thread_scheduler_with_semaphores #(
	parameter int unsigned MAX_THREADS = tss_pkg::MaxThreads,
	parameter int unsigned MAX_SEMS = tss_pkg::MaxSems
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  target_thread,
	input  logic [2:0]  sem_index,
	input  logic [15:0] sem_start_value,
	input  logic [31:0] exit_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  created_thread,
	output logic [3:0]  running_thread,
	output logic [31:0] joined_exit_word,
	output logic        exit_ready
);
	import tss_pkg::*;

	tss_cmd_t cmd;
	tss_sts_t sts;

	tss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	tss_datapath #(.MAX_THREADS(MAX_THREADS), .MAX_SEMS(MAX_SEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .target_thread(target_thread), .sem_index(sem_index),
		.sem_start_value(sem_start_value), .exit_word(exit_word),
		.res_status(status), .res_created(created_thread),
		.res_running(running_thread), .res_jw(joined_exit_word),
		.res_xr(exit_ready)
	);

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= STS_UNKNOWN)) else $error("bad status");
	a_xr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && exit_ready) |-> (status == STS_OK || status == STS_NONE))
		else $error("exit value with error status");
`endif

endmodule
